/* src/bpc_pkg.sv */
// Shared types and constants for the button press classifier / LED blinker.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_MIN_PRESS  = 3'd2,
        REG_PATTERN0   = 3'd3,
        REG_PATTERN1   = 3'd4,
        REG_PATTERN2   = 3'd5
    } reg_index_t;

    // Press classification reported with each result
    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_SHORT_TOGGLE = 3'd1,
        EV_LONG_ADVANCE = 3'd2,
        EV_LONG_IGNORED = 3'd3,
        EV_NOISE        = 3'd4
    } press_event_t;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd200;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [15:0] MIN_PRESS_RESET  = 16'd50;
    // bits 15..0 on time, bits 31..16 off time
    localparam logic [31:0] PATTERN0_RESET   = {16'd500, 16'd500};
    localparam logic [31:0] PATTERN1_RESET   = {16'd800, 16'd200};
    localparam logic [31:0] PATTERN2_RESET   = {16'd200, 16'd1000};
    localparam logic [1:0]  PATTERN_LAST     = 2'd2;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] min_press_ms;
        logic [31:0] pattern0;
        logic [31:0] pattern1;
        logic [31:0] pattern2;
    } cfg_t;

    // Fixed-width part of the per-tick state
    typedef struct packed {
        logic        button_held;
        logic        sequence_on;
        logic [1:0]  selected_pattern;
        logic [15:0] accepted_presses;
        logic        led_phase_on;
    } ctrl_state_t;

endpackage

`default_nettype wire

/* src/bpc_cfg_regs.sv */
// Configuration register file for the button press classifier.
// Depends on bpc_pkg (register indexes, reset values, cfg_t).
`default_nettype none

module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [31:0] wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DEBOUNCE:   cfg_next.debounce_ms   = wr_data[15:0];
                REG_LONG_PRESS: cfg_next.long_press_ms = wr_data[15:0];
                REG_MIN_PRESS:  cfg_next.min_press_ms  = wr_data[15:0];
                REG_PATTERN0:   cfg_next.pattern0      = wr_data;
                REG_PATTERN1:   cfg_next.pattern1      = wr_data;
                REG_PATTERN2:   cfg_next.pattern2      = wr_data;
                default:        cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
            cfg_reg.min_press_ms  <= MIN_PRESS_RESET;
            cfg_reg.pattern0      <= PATTERN0_RESET;
            cfg_reg.pattern1      <= PATTERN1_RESET;
            cfg_reg.pattern2      <= PATTERN2_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/bpc_tick_logic.sv */
// Per-tick next-state logic: debounce, press classification, blink phasing.
// Depends on bpc_pkg (cfg_t, ctrl_state_t, press_event_t).
`default_nettype none

module bpc_tick_logic
    import bpc_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  wire logic                 level,
    input  wire cfg_t                 cfg,
    input  wire ctrl_state_t          st,
    input  wire logic [TIME_BITS-1:0] since_release,
    input  wire logic [TIME_BITS-1:0] press_len,
    input  wire logic [TIME_BITS-1:0] phase_elapsed,
    output ctrl_state_t               st_next,
    output logic [TIME_BITS-1:0]      since_release_next,
    output logic [TIME_BITS-1:0]      press_len_next,
    output logic [TIME_BITS-1:0]      phase_elapsed_next,
    output logic [2:0]                press_event
);

    localparam logic [32:0] TMAX = (33'd1 << TIME_BITS) - 33'd1;

    // Limit a 16-bit threshold to the timer range
    function automatic logic [TIME_BITS-1:0] clampt(input logic [15:0] v);
        logic [32:0] ext;
        ext = {17'd0, v};
        if (ext > TMAX)
            return TMAX[TIME_BITS-1:0];
        return ext[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        if (v == {TIME_BITS{1'b1}})
            return v;
        return v + {{(TIME_BITS-1){1'b0}}, 1'b1};
    endfunction

    logic [TIME_BITS-1:0] tsr;
    logic [TIME_BITS-1:0] plen;
    logic [TIME_BITS-1:0] pe_inc;
    logic [31:0]          pat;
    logic [15:0]          len;
    logic                 started;

    always_comb
    begin
        st_next     = st;
        tsr         = since_release;
        plen        = press_len;
        started     = 1'b0;
        press_event = EV_NONE;

        if (since_release >= clampt(cfg.debounce_ms))
        begin
            if (level && !st.button_held)
            begin
                st_next.button_held = 1'b1;
                plen                = '0;
            end
            else if (!level && st.button_held)
            begin
                st_next.button_held = 1'b0;
                if (press_len >= clampt(cfg.long_press_ms))
                begin
                    if (st.sequence_on)
                    begin
                        st_next.selected_pattern = (st.selected_pattern >= PATTERN_LAST) ?
                                                   2'd0 : st.selected_pattern + 2'd1;
                        press_event = EV_LONG_ADVANCE;
                    end
                    else
                    begin
                        press_event = EV_LONG_IGNORED;
                    end
                end
                else if (press_len >= clampt(cfg.min_press_ms))
                begin
                    st_next.accepted_presses = st.accepted_presses + 16'd1;
                    st_next.sequence_on      = !st.sequence_on;
                    started                  = !st.sequence_on;
                    press_event              = EV_SHORT_TOGGLE;
                end
                else
                begin
                    press_event = EV_NOISE;
                end
                tsr = '0;
            end
        end

        // Pattern lookup uses the pattern selected in this tick
        case (st_next.selected_pattern)
            2'd1:    pat = cfg.pattern1;
            2'd2:    pat = cfg.pattern2;
            default: pat = cfg.pattern0;
        endcase
        len    = st.led_phase_on ? pat[15:0] : pat[31:16];
        pe_inc = sat_inc(phase_elapsed);

        if (!st_next.sequence_on)
        begin
            st_next.led_phase_on = 1'b0;
            phase_elapsed_next   = '0;
        end
        else if (started)
        begin
            st_next.led_phase_on = 1'b1;
            phase_elapsed_next   = '0;
        end
        else if (pe_inc >= clampt(len))
        begin
            st_next.led_phase_on = !st.led_phase_on;
            phase_elapsed_next   = '0;
        end
        else
        begin
            phase_elapsed_next = pe_inc;
        end

        since_release_next = sat_inc(tsr);
        press_len_next     = sat_inc(plen);
    end

endmodule

`default_nettype wire

/* src/button_press_classifier_led_blinker.sv */
// Button press classifier with LED blink patterns: top level.
// Depends on bpc_pkg, bpc_cfg_regs and bpc_tick_logic.
//
// Usage:
//   Input channel (in_valid / in_stall / button_level): one request per
//   millisecond tick carrying the sampled button level.
//   Output channel (out_valid / out_stall / led_on ... press_event): exactly
//   one result per input request, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready
//   is always high; write only while the block is idle. Unknown indexes are
//   dropped.
// Flow: an accepted request is captured in the input register, then evaluated
//   and written to the result register once the result slot is free; the result
//   is offered from the result register until it is taken.
// Throughput: one request per cycle while the output is not stalled; the state
//   update is a single pass of compare/increment logic between the input and result registers.
// Reset: timers, state and both stage valids clear; config registers load
//   their defaults (200 / 1000 / 50 ms, patterns 500/500, 200/800, 1000/200).
// Stall: a stalled result holds; the input register still fills, and
//   in_stall rises only once both stages are occupied.
`default_nettype none

module button_press_classifier_led_blinker
    import bpc_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        button_level,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             led_on,
    output logic             blinking_enabled,
    output logic [1:0]       pattern_index,
    output logic [15:0]      short_press_count,
    output logic [2:0]       press_event,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t cfg;

    // Configuration is always accepted
    assign cfg_ready = 1'b1;

    bpc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input register
    logic s1_valid_reg;
    logic s1_level_reg;

    // Block state
    ctrl_state_t          state_reg;
    ctrl_state_t          state_next;
    logic [TIME_BITS-1:0] since_release_reg;
    logic [TIME_BITS-1:0] since_release_next;
    logic [TIME_BITS-1:0] press_len_reg;
    logic [TIME_BITS-1:0] press_len_next;
    logic [TIME_BITS-1:0] phase_elapsed_reg;
    logic [TIME_BITS-1:0] phase_elapsed_next;
    logic [2:0]           event_next;

    // Result register
    logic        out_valid_reg;
    logic        led_on_reg;
    logic        blinking_reg;
    logic [1:0]  pattern_reg;
    logic [15:0] count_reg;
    logic [2:0]  event_reg;

    logic out_free;
    logic s1_adv;
    logic in_take;

    // Result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    bpc_tick_logic #(
        .TIME_BITS (TIME_BITS)
    ) u_tick_logic (
        .level              (s1_level_reg),
        .cfg                (cfg),
        .st                 (state_reg),
        .since_release      (since_release_reg),
        .press_len          (press_len_reg),
        .phase_elapsed      (phase_elapsed_reg),
        .st_next            (state_next),
        .since_release_next (since_release_next),
        .press_len_next     (press_len_next),
        .phase_elapsed_next (phase_elapsed_next),
        .press_event        (event_next)
    );

    // Control: stage valids and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg         <= '0;
            since_release_reg <= '0;
            press_len_reg     <= '0;
            phase_elapsed_reg <= '0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // Advance the state once per evaluated tick
            if (s1_adv)
            begin
                state_reg         <= state_next;
                since_release_reg <= since_release_next;
                press_len_reg     <= press_len_next;
                phase_elapsed_reg <= phase_elapsed_next;
            end
        end
    end

    // Payload: input capture and result fields
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_level_reg <= button_level;
        if (s1_adv)
        begin
            led_on_reg   <= state_next.led_phase_on && state_next.sequence_on;
            blinking_reg <= state_next.sequence_on;
            pattern_reg  <= state_next.selected_pattern;
            count_reg    <= state_next.accepted_presses;
            event_reg    <= event_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign led_on            = led_on_reg;
    assign blinking_enabled  = blinking_reg;
    assign pattern_index     = pattern_reg;
    assign short_press_count = count_reg;
    assign press_event       = event_reg;

    // LED only lights while blinking is on
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!led_on || blinking_enabled))
        else $error("led on while blinking disabled");

    // Selected pattern stays within the three patterns
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.selected_pattern != 2'd3)
        else $error("selected pattern out of range");

    // Every evaluated tick produces a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid)
        else $error("evaluated tick lost its result");

    // Press count moves only with a short toggle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && event_next != EV_SHORT_TOGGLE) |=>
            state_reg.accepted_presses == $past(state_reg.accepted_presses))
        else $error("press count changed without a short press");

endmodule

`default_nettype wire
